[design/h264it_pkg.sv]
`default_nettype none
package h264it_pkg;

  localparam int WordW    = 24;
  localparam int CoefW    = 16;
  localparam int PixW     = 8;
  localparam int IdxW     = 6;
  localparam int BlkMax   = 64;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 3;

  typedef logic signed [WordW-1:0] word_t;
  typedef logic [7:0][WordW-1:0] vec_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_EIGHT = 2'd0,
    REG_SHIFT = 2'd1,
    REG_ADD   = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROW_RD,
    ST_ROW_WR,
    ST_COL_RD,
    ST_COL_WR,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_ROW_RD,
    OP_ROW_WR,
    OP_COL_RD,
    OP_COL_WR,
    OP_EMIT_RD,
    OP_EMIT_LD
  } op_e;

  typedef struct packed {
    op_e            op;
    logic           issue;
    logic           snap;
    logic [2:0]     outer;
    logic [2:0]     k;
    logic [6:0]     load_cnt;
    logic [IdxW-1:0] emit_idx;
    logic           emit_last;
  } cmd_t;

  typedef struct packed {
    logic eight;
    logic out_free;
  } status_t;

  function automatic vec_t idct4(vec_t x);
    word_t x0, x1, x2, x3, z0, z1, z2, z3;
    vec_t  y;
    x0 = x[0];
    x1 = x[1];
    x2 = x[2];
    x3 = x[3];
    z0 = x0 + x2;
    z1 = x0 - x2;
    z2 = (x1 >>> 1) - x3;
    z3 = x1 + (x3 >>> 1);
    y    = '0;
    y[0] = z0 + z3;
    y[1] = z1 + z2;
    y[2] = z1 - z2;
    y[3] = z0 - z3;
    return y;
  endfunction

  function automatic vec_t idct8(vec_t x);
    word_t x0, x1, x2, x3, x4, x5, x6, x7;
    word_t e0, e2, e4, e6, f0, f2, f4, f6;
    word_t o1, o3, o5, o7, g1, g3, g5, g7;
    vec_t  y;
    x0 = x[0];
    x1 = x[1];
    x2 = x[2];
    x3 = x[3];
    x4 = x[4];
    x5 = x[5];
    x6 = x[6];
    x7 = x[7];
    e0 = x0 + x4;
    e2 = x0 - x4;
    e4 = (x2 >>> 1) - x6;
    e6 = (x6 >>> 1) + x2;
    f0 = e0 + e6;
    f2 = e2 + e4;
    f4 = e2 - e4;
    f6 = e0 - e6;
    o1 = x5 - x3 - x7 - (x7 >>> 1);
    o3 = x1 + x7 - x3 - (x3 >>> 1);
    o5 = x7 - x1 + x5 + (x5 >>> 1);
    o7 = x3 + x5 + x1 + (x1 >>> 1);
    g1 = (o7 >>> 2) + o1;
    g3 = o3 + (o5 >>> 2);
    g5 = (o3 >>> 2) - o5;
    g7 = o7 - (o1 >>> 2);
    y[0] = f0 + g7;
    y[7] = f0 - g7;
    y[1] = f2 + g5;
    y[6] = f2 - g5;
    y[2] = f4 + g3;
    y[5] = f4 - g3;
    y[3] = f6 + g1;
    y[4] = f6 - g1;
    return y;
  endfunction

endpackage
`default_nettype wire

[design/h264it_if.sv]
`default_nettype none
interface h264it_in_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] coefficient;
  logic [7:0]  pred_sample;
  modport source (output valid, coefficient, pred_sample, input ready);
  modport sink (input valid, coefficient, pred_sample, output ready);
endinterface

interface h264it_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic [5:0] sample_index;
  logic       block_done;
  modport source (output valid, pixel, sample_index, block_done, input ready);
  modport sink (input valid, pixel, sample_index, block_done, output ready);
endinterface

interface h264it_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [2:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/h264_inverse_transform_add_core.sv]
// H.264 inverse integer transform with optional prediction add for 4x4 or 8x8 blocks.
// Coefficient and prediction beats enter on in_ch_i in raster order, one
// sample per beat at one beat per cycle while loading. The beat that
// completes the block samples the size, shift and add mode registers
// written over cfg_i, which is always ready. The block then runs the row
// pass and the column pass over a 16-bit working memory, one sample per
// cycle through a shared butterfly unit, and stores the clipped pixels
// for raster output. Output beats leave on out_ch_o: each is read from
// the result memory by a registered read and then loaded into the output
// register; block_done marks the last beat. The output register holds
// its beat while the receiver stalls and the block waits with it. No
// input is accepted from the completing beat until the last output beat
// is read from the result memory.
// Reset clears the load count and sets the registers to 4x4, shift 6 and
// add mode; the sample memories need no clearing.
`default_nettype none
module h264_inverse_transform_add_core #(
  parameter int MAX_BLOCK_SAMPLES = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  h264it_in_if.sink    in_ch_i,
  h264it_out_if.source out_ch_o,
  h264it_cfg_if.sink   cfg_i
);

  logic       eight_q;
  logic [2:0] shift_q;
  logic       add_q;
  h264it_pkg::cmd_t    cmd;
  h264it_pkg::status_t status;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eight_q <= 1'b0;
      shift_q <= 3'd6;
      add_q   <= 1'b1;
    end else if (cfg_i.valid) begin
      case (h264it_pkg::reg_idx_e'(cfg_i.index))
        h264it_pkg::REG_EIGHT: eight_q <= cfg_i.data[0];
        h264it_pkg::REG_SHIFT: shift_q <= cfg_i.data;
        h264it_pkg::REG_ADD:   add_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  h264it_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch_i.valid),
    .in_ready_o   (in_ch_i.ready),
    .live_eight_i (eight_q),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  h264it_datapath #(.MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES)) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_eight_i    (eight_q),
    .cfg_shift_i    (shift_q),
    .cfg_add_i      (add_q),
    .coefficient_i  (in_ch_i.coefficient),
    .pred_sample_i  (in_ch_i.pred_sample),
    .out_valid_o    (out_ch_o.valid),
    .out_ready_i    (out_ch_o.ready),
    .pixel_o        (out_ch_o.pixel),
    .sample_index_o (out_ch_o.sample_index),
    .block_done_o   (out_ch_o.block_done)
  );

endmodule
`default_nettype wire

[design/h264it_ram.sv]
`default_nettype none
module h264it_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[design/h264it_ctrl.sv]
`default_nettype none
module h264it_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 live_eight_i,
  input  wire h264it_pkg::status_t  status_i,
  output h264it_pkg::cmd_t          cmd_o
);

  h264it_pkg::state_e state_q, state_d;
  logic [6:0] cnt_q, cnt_d, cnt_next;
  logic [2:0] outer_q, outer_d;
  logic [3:0] k_q, k_d;
  logic [5:0] emit_q, emit_d;
  logic [3:0] n_len;
  logic [2:0] outer_last;
  logic [5:0] emit_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= h264it_pkg::ST_LOAD;
      cnt_q   <= '0;
      outer_q <= '0;
      k_q     <= '0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      outer_q <= outer_d;
      k_q     <= k_d;
      emit_q  <= emit_d;
    end
  end

  always_comb begin
    n_len      = status_i.eight ? 4'd8 : 4'd4;
    outer_last = status_i.eight ? 3'd7 : 3'd3;
    emit_end   = status_i.eight ? 6'd63 : 6'd15;
    cnt_next   = cnt_q + 7'd1;
    state_d    = state_q;
    cnt_d      = cnt_q;
    outer_d    = outer_q;
    k_d        = k_q;
    emit_d     = emit_q;
    in_ready_o = 1'b0;
    cmd_o           = '0;
    cmd_o.op        = h264it_pkg::OP_IDLE;
    cmd_o.outer     = outer_q;
    cmd_o.k         = k_q[2:0];
    cmd_o.load_cnt  = cnt_q;
    cmd_o.emit_idx  = emit_q;
    cmd_o.emit_last = (emit_q == emit_end);
    case (state_q)
      h264it_pkg::ST_LOAD: begin
        in_ready_o  = 1'b1;
        cmd_o.op    = h264it_pkg::OP_LOAD;
        cmd_o.issue = in_valid_i;
        if (in_valid_i) begin
          if (cnt_next >= (live_eight_i ? 7'd64 : 7'd16)) begin
            cnt_d      = '0;
            cmd_o.snap = 1'b1;
            outer_d    = '0;
            k_d        = '0;
            state_d    = h264it_pkg::ST_ROW_RD;
          end else begin
            cnt_d = cnt_next;
          end
        end
      end
      h264it_pkg::ST_ROW_RD, h264it_pkg::ST_COL_RD: begin
        cmd_o.op    = (state_q == h264it_pkg::ST_ROW_RD) ? h264it_pkg::OP_ROW_RD
                                                          : h264it_pkg::OP_COL_RD;
        cmd_o.issue = (k_q < n_len);
        if (k_q == n_len) begin
          k_d     = '0;
          state_d = (state_q == h264it_pkg::ST_ROW_RD) ? h264it_pkg::ST_ROW_WR
                                                        : h264it_pkg::ST_COL_WR;
        end else begin
          k_d = k_q + 4'd1;
        end
      end
      h264it_pkg::ST_ROW_WR: begin
        cmd_o.op    = h264it_pkg::OP_ROW_WR;
        cmd_o.issue = 1'b1;
        if (k_q == n_len - 4'd1) begin
          k_d = '0;
          if (outer_q == outer_last) begin
            outer_d = '0;
            state_d = h264it_pkg::ST_COL_RD;
          end else begin
            outer_d = outer_q + 3'd1;
            state_d = h264it_pkg::ST_ROW_RD;
          end
        end else begin
          k_d = k_q + 4'd1;
        end
      end
      h264it_pkg::ST_COL_WR: begin
        cmd_o.op    = h264it_pkg::OP_COL_WR;
        cmd_o.issue = (k_q < n_len);
        if (k_q == n_len) begin
          k_d = '0;
          if (outer_q == outer_last) begin
            outer_d = '0;
            emit_d  = '0;
            state_d = h264it_pkg::ST_EMIT_RD;
          end else begin
            outer_d = outer_q + 3'd1;
            state_d = h264it_pkg::ST_COL_RD;
          end
        end else begin
          k_d = k_q + 4'd1;
        end
      end
      h264it_pkg::ST_EMIT_RD: begin
        cmd_o.op    = h264it_pkg::OP_EMIT_RD;
        cmd_o.issue = status_i.out_free;
        if (status_i.out_free) begin
          state_d = h264it_pkg::ST_EMIT_LD;
        end
      end
      h264it_pkg::ST_EMIT_LD: begin
        cmd_o.op    = h264it_pkg::OP_EMIT_LD;
        cmd_o.issue = 1'b1;
        if (emit_q == emit_end) begin
          state_d = h264it_pkg::ST_LOAD;
        end else begin
          emit_d  = emit_q + 6'd1;
          state_d = h264it_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_d = h264it_pkg::ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

[design/h264it_datapath.sv]
`default_nettype none
module h264it_datapath #(
  parameter int MAX_BLOCK_SAMPLES = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire h264it_pkg::cmd_t    cmd_i,
  output h264it_pkg::status_t      status_o,
  input  wire logic                cfg_eight_i,
  input  wire logic [2:0]          cfg_shift_i,
  input  wire logic                cfg_add_i,
  input  wire logic signed [15:0]  coefficient_i,
  input  wire logic [7:0]          pred_sample_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [7:0]               pixel_o,
  output logic [5:0]               sample_index_o,
  output logic                     block_done_o
);

  localparam int AW = $clog2(MAX_BLOCK_SAMPLES);
  localparam logic [6:0] MaxCnt = 7'(MAX_BLOCK_SAMPLES);

  logic       eight_q, add_q;
  logic [2:0] shift_q;
  h264it_pkg::vec_t x_q, y;

  logic            cap_valid_q;
  h264it_pkg::op_e cap_op_q;
  logic [2:0]      cap_k_q;
  logic [5:0]      cap_addr_q;
  logic            cap_zero_q;
  logic            cap_last_q;
  logic            cap_valid_d;
  logic [5:0]      cap_addr_d;
  logic            cap_zero_d;

  logic [5:0] row_idx, col_idx;
  logic       store_ok;
  logic [15:0] coef_rdata, work_rdata, round, row_val;
  logic [7:0]  pred_rdata, res_rdata, pix;
  logic        ov_q;
  h264it_pkg::word_t yk, ysh, ysum;

  always_comb begin
    row_idx = eight_q ? {cmd_i.outer, cmd_i.k} : {2'b00, cmd_i.outer[1:0], cmd_i.k[1:0]};
    col_idx = eight_q ? {cmd_i.k, cmd_i.outer} : {2'b00, cmd_i.k[1:0], cmd_i.outer[1:0]};
    store_ok = (cmd_i.op == h264it_pkg::OP_LOAD) && cmd_i.issue && (cmd_i.load_cnt < MaxCnt);
    cap_valid_d = cmd_i.issue && ((cmd_i.op == h264it_pkg::OP_ROW_RD) ||
                                  (cmd_i.op == h264it_pkg::OP_COL_RD) ||
                                  (cmd_i.op == h264it_pkg::OP_COL_WR) ||
                                  (cmd_i.op == h264it_pkg::OP_EMIT_RD));
    case (cmd_i.op)
      h264it_pkg::OP_COL_RD, h264it_pkg::OP_COL_WR: cap_addr_d = col_idx;
      h264it_pkg::OP_EMIT_RD:                       cap_addr_d = cmd_i.emit_idx;
      default:                                      cap_addr_d = row_idx;
    endcase
    cap_zero_d = ({1'b0, cap_addr_d} >= MaxCnt);
  end

  h264it_ram #(.WIDTH(16), .DEPTH(MAX_BLOCK_SAMPLES)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (store_ok),
    .waddr_i (cmd_i.load_cnt[AW-1:0]),
    .wdata_i (coefficient_i),
    .re_i    (cmd_i.issue && (cmd_i.op == h264it_pkg::OP_ROW_RD)),
    .raddr_i (row_idx[AW-1:0]),
    .rdata_o (coef_rdata)
  );

  h264it_ram #(.WIDTH(8), .DEPTH(MAX_BLOCK_SAMPLES)) u_pred_ram (
    .clk_i   (clk_i),
    .we_i    (store_ok),
    .waddr_i (cmd_i.load_cnt[AW-1:0]),
    .wdata_i (pred_sample_i),
    .re_i    (cmd_i.issue && (cmd_i.op == h264it_pkg::OP_COL_WR)),
    .raddr_i (col_idx[AW-1:0]),
    .rdata_o (pred_rdata)
  );

  h264it_ram #(.WIDTH(16), .DEPTH(h264it_pkg::BlkMax)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.issue && (cmd_i.op == h264it_pkg::OP_ROW_WR)),
    .waddr_i (row_idx),
    .wdata_i (y[cmd_i.k][15:0]),
    .re_i    (cmd_i.issue && (cmd_i.op == h264it_pkg::OP_COL_RD)),
    .raddr_i (col_idx),
    .rdata_o (work_rdata)
  );

  h264it_ram #(.WIDTH(8), .DEPTH(h264it_pkg::BlkMax)) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (cap_valid_q && (cap_op_q == h264it_pkg::OP_COL_WR)),
    .waddr_i (cap_addr_q),
    .wdata_i (pix),
    .re_i    (cmd_i.issue && (cmd_i.op == h264it_pkg::OP_EMIT_RD)),
    .raddr_i (cmd_i.emit_idx),
    .rdata_o (res_rdata)
  );

  always_comb begin
    y     = eight_q ? h264it_pkg::idct8(x_q) : h264it_pkg::idct4(x_q);
    round = (shift_q == 3'd0) ? 16'd0 : (16'd1 << (shift_q - 3'd1));
    row_val = cap_zero_q ? 16'd0 : coef_rdata;
    if (cap_addr_q == 6'd0) begin
      row_val = row_val + round;
    end
    yk   = y[cap_k_q];
    ysh  = yk >>> shift_q;
    ysum = ysh + (add_q && !cap_zero_q ? h264it_pkg::word_t'({16'd0, pred_rdata}) : '0);
    if (ysum < 0) begin
      pix = 8'd0;
    end else if (ysum > 255) begin
      pix = 8'd255;
    end else begin
      pix = ysum[7:0];
    end
    status_o.eight    = eight_q;
    status_o.out_free = !ov_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_valid_q <= 1'b0;
      cap_op_q    <= h264it_pkg::OP_IDLE;
      ov_q        <= 1'b0;
      eight_q     <= 1'b0;
      shift_q     <= 3'd6;
      add_q       <= 1'b1;
    end else begin
      cap_valid_q <= cap_valid_d;
      cap_op_q    <= cmd_i.op;
      if (cmd_i.snap) begin
        eight_q <= cfg_eight_i;
        shift_q <= cfg_shift_i;
        add_q   <= cfg_add_i;
      end
      if (cmd_i.op == h264it_pkg::OP_EMIT_LD) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cap_k_q    <= cmd_i.k;
    cap_addr_q <= cap_addr_d;
    cap_zero_q <= cap_zero_d;
    cap_last_q <= cmd_i.emit_last;
    if (cap_valid_q && (cap_op_q == h264it_pkg::OP_ROW_RD)) begin
      x_q[cap_k_q] <= {{8{row_val[15]}}, row_val};
    end else if (cap_valid_q && (cap_op_q == h264it_pkg::OP_COL_RD)) begin
      x_q[cap_k_q] <= {{8{work_rdata[15]}}, work_rdata};
    end
    if (cmd_i.op == h264it_pkg::OP_EMIT_LD) begin
      pixel_o        <= res_rdata;
      sample_index_o <= cap_addr_q;
      block_done_o   <= cap_last_q;
    end
  end

  assign out_valid_o = ov_q;

endmodule
`default_nettype wire
